### sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KSH_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define KSH_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### sv/kshfc_pkg.sv
// ----------------------------------------------------------------------------
// kshfc_pkg
// Types, codes and digit helpers for the keypad setpoint fan controller.
// ----------------------------------------------------------------------------
`default_nettype none

package kshfc_pkg;

   typedef logic [6:0]  duty_type;
   typedef logic [8:0]  thr_type;
   typedef logic [3:0]  key_type;
   typedef logic [2:0]  slot_type;
   typedef logic [11:0] lines_type;
   typedef logic [7:0]  sample_type;
   typedef logic [0:0]  csr_index_type;
   typedef logic [1:0]  pos_type;

   localparam key_type KEY_CANCEL = 4'd10;
   localparam key_type KEY_ENTER  = 4'd11;
   localparam key_type KEY_NONE   = 4'd12;
   localparam key_type KEY_DIGIT_MAX = 4'd9;

   localparam csr_index_type CSR_DUTY_HIGH = 1'd0;
   localparam csr_index_type CSR_DUTY_LOW  = 1'd1;

   localparam duty_type DUTY_HIGH_RST = 7'd95;
   localparam duty_type DUTY_LOW_RST  = 7'd5;
   localparam thr_type  THR_OFF_RST   = 9'd50;
   localparam thr_type  THR_ON_RST    = 9'd100;

   localparam slot_type SLOT_FIRST    = 3'd0;
   localparam slot_type SLOT_OFF_WAIT = 3'd3;
   localparam slot_type SLOT_ON_FIRST = 3'd4;
   localparam slot_type SLOT_ON_WAIT  = 3'd7;

   localparam pos_type POS_HUN = 2'd0;
   localparam pos_type POS_TEN = 2'd1;
   localparam pos_type POS_ONE = 2'd2;

   localparam key_type HUN_MAX   = 4'd2;
   localparam key_type LOWER_MAX = 4'd5;
   localparam thr_type TEN_LIMIT_VAL = 9'd200;
   localparam thr_type ONE_LIMIT_VAL = 9'd250;

   typedef enum logic [1:0] {
      LEVEL_NONE = 2'd0,
      LEVEL_HIGH = 2'd1,
      LEVEL_LOW  = 2'd2
   } level_type;

   typedef enum logic {
      MODE_MAIN  = 1'b0,
      MODE_SETUP = 1'b1
   } mode_type;

   typedef struct packed {
      logic [3:0] hun;
      logic [3:0] ten;
      logic [3:0] one;
   } digits_type;

   // scan position to key code, order 1..9,*,0,#
   function automatic key_type key_code(input logic [3:0] idx);
      key_type code;
      unique case (idx)
         4'd9:    code = KEY_CANCEL;
         4'd10:   code = 4'd0;
         4'd11:   code = KEY_ENTER;
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8:
                  code = idx + 4'd1;
         default: code = KEY_NONE;
      endcase
      return code;
   endfunction

   // decimal digits of a 9-bit value, divide by ten as multiply by 205 >> 11
   function automatic digits_type split_digits(input thr_type v);
      logic [16:0] prod1;
      logic [5:0]  q;
      logic [13:0] prod2;
      digits_type  dg;
      prod1  = 17'(v) * 17'd205;
      q      = prod1[16:11];
      prod2  = 14'(q) * 14'd205;
      dg.hun = {1'b0, prod2[13:11]};
      dg.ten = 4'(q - 6'(prod2[13:11]) * 6'd10);
      dg.one = 4'(v - 9'(q) * 9'd10);
      return dg;
   endfunction

   function automatic thr_type put_digit(input thr_type v, input pos_type pos,
                                         input key_type d);
      digits_type dg;
      logic [9:0] sum;
      dg = split_digits(v);
      unique case (pos)
         POS_HUN: dg.hun = d;
         POS_TEN: dg.ten = d;
         default: dg.one = d;
      endcase
      sum = 10'(dg.hun) * 10'd100 + 10'(dg.ten) * 10'd10 + 10'(dg.one);
      return sum[8:0];
   endfunction

   function automatic logic digit_bad(input thr_type v, input pos_type pos,
                                      input key_type d);
      logic bad;
      unique case (pos)
         POS_HUN: bad = (d > HUN_MAX);
         POS_TEN: bad = (v == TEN_LIMIT_VAL) && (d > LOWER_MAX);
         default: bad = (v == ONE_LIMIT_VAL) && (d > LOWER_MAX);
      endcase
      return bad;
   endfunction

endpackage

`default_nettype wire

### sv/kshfc_req_if.sv
// ----------------------------------------------------------------------------
// kshfc_req_if
// Input channel: temperature sample and raw key levels, one beat per pass.
// ----------------------------------------------------------------------------
`default_nettype none

interface kshfc_req_if;
   import kshfc_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   lines_type  key_lines;

   modport source (output valid, output sample, output key_lines, input ready);
   modport sink   (input valid, input sample, input key_lines, output ready);
endinterface

`default_nettype wire

### sv/kshfc_rsp_if.sv
// ----------------------------------------------------------------------------
// kshfc_rsp_if
// Result channel: fan duty and threshold entry status, one beat per pass.
// ----------------------------------------------------------------------------
`default_nettype none

interface kshfc_rsp_if;
   import kshfc_pkg::*;

   logic     valid;
   logic     ready;
   duty_type fan_duty;
   logic     in_setup;
   slot_type entry_position;
   thr_type  off_threshold;
   thr_type  on_threshold;
   thr_type  pending_off;
   thr_type  pending_on;
   key_type  key_event;
   logic     entry_rejected;

   modport source (output valid, output fan_duty, output in_setup,
                   output entry_position, output off_threshold, output on_threshold,
                   output pending_off, output pending_on, output key_event,
                   output entry_rejected, input ready);
   modport sink   (input valid, input fan_duty, input in_setup,
                   input entry_position, input off_threshold, input on_threshold,
                   input pending_off, input pending_on, input key_event,
                   input entry_rejected, output ready);
endinterface

`default_nettype wire

### sv/kshfc_csr_if.sv
// ----------------------------------------------------------------------------
// kshfc_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface kshfc_csr_if;
   import kshfc_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   duty_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/keypad_setpoint_hysteresis_fan_control.sv
// ----------------------------------------------------------------------------
// keypad_setpoint_hysteresis_fan_control
// Keypad edge detect, threshold entry sequencer and hysteresis fan duty.
// ----------------------------------------------------------------------------
// result beats are registered, offered the cycle after the request is taken
// throughput: one request beat per cycle unless the result is stalled; the
//   only stage, the output register, refills in the cycle its beat is taken
// reset (synchronous, active high): duty 95/5, thresholds 50/100, key memory
//   all pressed, fan undecided, main mode, slot 0, edits zero, no result
`default_nettype none

module keypad_setpoint_hysteresis_fan_control (
   input  wire              clock,
   input  wire              reset,
   kshfc_req_if.sink        req_bus,
   kshfc_rsp_if.source      rsp_bus,
   kshfc_csr_if.sink        csr_bus
);
   import kshfc_pkg::*;

   // configuration
   duty_type  duty_high_ff, duty_low_ff;

   // loop state
   lines_type key_mem_ff,    key_mem_in;
   level_type level_ff,      level_in;
   mode_type  mode_ff,       mode_in;
   slot_type  slot_ff,       slot_in;
   thr_type   commit_off_ff, commit_off_in;
   thr_type   commit_on_ff,  commit_on_in;
   thr_type   edit_off_ff,   edit_off_in;
   thr_type   edit_on_ff,    edit_on_in;

   // result register
   logic      rsp_valid_ff;
   duty_type  duty_ff,       duty_in;
   key_type   key_ff,        key_in;
   logic      rejected_ff,   rejected_in;

   logic      req_fire;
   logic      csr_fire;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid;

   always_comb begin
      thr_type tgt;
      logic    in_on;
      logic    bad;
      tgt           = edit_off_ff;
      in_on         = slot_ff[2];
      bad           = 1'b0;
      key_in        = KEY_NONE;
      key_mem_in    = req_bus.key_lines;
      level_in      = level_ff;
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      commit_off_in = commit_off_ff;
      commit_on_in  = commit_on_ff;
      edit_off_in   = edit_off_ff;
      edit_on_in    = edit_on_ff;

      // released-to-pressed edge, later scan positions override earlier ones
      for (int i = 0; i < 12; i++) begin
         if (key_mem_ff[i] && !req_bus.key_lines[i]) begin
            key_in = key_code(4'(i));
         end
      end

      // low decision last so it wins when both hold
      if ({1'b0, req_bus.sample} > commit_on_ff) begin
         level_in = LEVEL_HIGH;
      end
      if ({1'b0, req_bus.sample} < commit_off_ff) begin
         level_in = LEVEL_LOW;
      end

      if (in_on) begin
         tgt = edit_on_ff;
      end

      unique case (mode_ff)
         MODE_MAIN: begin
            if (key_in == KEY_ENTER) begin
               mode_in     = MODE_SETUP;
               edit_off_in = commit_off_ff;
               edit_on_in  = commit_on_ff;
               slot_in     = SLOT_FIRST;
            end
         end
         MODE_SETUP: begin
            priority if (key_in == KEY_ENTER) begin
               priority if (slot_ff < SLOT_OFF_WAIT) begin
                  if (edit_off_ff == '0) begin
                     bad = 1'b1;
                  end else begin
                     slot_in = SLOT_ON_FIRST;
                  end
               end else if (slot_ff == SLOT_OFF_WAIT) begin
                  slot_in    = SLOT_ON_FIRST;
                  edit_on_in = '0;
               end else if (edit_off_ff < edit_on_ff) begin
                  commit_off_in = edit_off_ff;
                  commit_on_in  = edit_on_ff;
                  mode_in       = MODE_MAIN;
               end else begin
                  bad = 1'b1;
               end
            end else if (key_in == KEY_CANCEL) begin
               mode_in = MODE_MAIN;
            end else if (key_in <= KEY_DIGIT_MAX) begin
               if (slot_ff == SLOT_OFF_WAIT || slot_ff == SLOT_ON_WAIT) begin
                  bad = 1'b1;
               end else begin
                  bad = digit_bad(tgt, slot_ff[1:0], key_in);
                  if (!bad) begin
                     if (in_on) begin
                        edit_on_in = put_digit(tgt, slot_ff[1:0], key_in);
                     end else begin
                        edit_off_in = put_digit(tgt, slot_ff[1:0], key_in);
                     end
                     slot_in = slot_ff + 3'd1;
                  end
               end
            end else begin
               slot_in = slot_ff;
            end
         end
         default: begin
            mode_in = MODE_MAIN;
         end
      endcase

      // invalid entry reloads the committed pair and restarts at slot 0
      if (bad) begin
         edit_off_in = commit_off_ff;
         edit_on_in  = commit_on_ff;
         slot_in     = SLOT_FIRST;
      end
      rejected_in = bad;

      unique case (level_in)
         LEVEL_HIGH: duty_in = duty_high_ff;
         LEVEL_LOW:  duty_in = duty_low_ff;
         default:    duty_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_high_ff <= DUTY_HIGH_RST;
         duty_low_ff  <= DUTY_LOW_RST;
      end else if (csr_fire) begin
         unique case (csr_bus.index)
            CSR_DUTY_HIGH: duty_high_ff <= csr_bus.data;
            CSR_DUTY_LOW:  duty_low_ff  <= csr_bus.data;
            default:       duty_high_ff <= duty_high_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mem_ff    <= '0;
         level_ff      <= LEVEL_NONE;
         mode_ff       <= MODE_MAIN;
         slot_ff       <= SLOT_FIRST;
         commit_off_ff <= THR_OFF_RST;
         commit_on_ff  <= THR_ON_RST;
         edit_off_ff   <= '0;
         edit_on_ff    <= '0;
      end else if (req_fire) begin
         key_mem_ff    <= key_mem_in;
         level_ff      <= level_in;
         mode_ff       <= mode_in;
         slot_ff       <= slot_in;
         commit_off_ff <= commit_off_in;
         commit_on_ff  <= commit_on_in;
         edit_off_ff   <= edit_off_in;
         edit_on_ff    <= edit_on_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         duty_ff     <= duty_in;
         key_ff      <= key_in;
         rejected_ff <= rejected_in;
      end
   end

   // state registers hold the end-of-pass values, so they double as payload
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.fan_duty       = duty_ff;
   assign rsp_bus.in_setup       = (mode_ff == MODE_SETUP);
   assign rsp_bus.entry_position = slot_ff;
   assign rsp_bus.off_threshold  = commit_off_ff;
   assign rsp_bus.on_threshold   = commit_on_ff;
   assign rsp_bus.pending_off    = edit_off_ff;
   assign rsp_bus.pending_on     = edit_on_ff;
   assign rsp_bus.key_event      = key_ff;
   assign rsp_bus.entry_rejected = rejected_ff;

endmodule

`default_nettype wire

### sv/kshfc_checker.sv
// ----------------------------------------------------------------------------
// kshfc_checker
// Port-level checks on the fan controller, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kshfc_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input wire               rsp_in_setup,
   input wire kshfc_pkg::slot_type rsp_entry_position,
   input wire kshfc_pkg::thr_type  rsp_off_threshold,
   input wire kshfc_pkg::thr_type  rsp_on_threshold,
   input wire kshfc_pkg::key_type  rsp_key_event,
   input wire               rsp_entry_rejected
);
   import kshfc_pkg::*;

   // a stalled result beat stays offered
   `KSH_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // every accepted request shows its result on the next cycle
   `KSH_ASSERT_NXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)

   // a rejection keeps entry mode and restarts at the first digit
   `KSH_ASSERT_IMP(a_reject_restart, clock, reset, rsp_valid && rsp_entry_rejected,
      rsp_in_setup && rsp_entry_position == SLOT_FIRST)

   // commit only happens with off below on
   `KSH_ASSERT_IMP(a_commit_order, clock, reset, rsp_valid,
      rsp_off_threshold < rsp_on_threshold)

   `KSH_ASSERT_IMP(a_key_range, clock, reset, rsp_valid, rsp_key_event <= KEY_NONE)

endmodule

bind keypad_setpoint_hysteresis_fan_control kshfc_checker u_kshfc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_in_setup       (rsp_bus.in_setup),
   .rsp_entry_position (rsp_bus.entry_position),
   .rsp_off_threshold  (rsp_bus.off_threshold),
   .rsp_on_threshold   (rsp_bus.on_threshold),
   .rsp_key_event      (rsp_bus.key_event),
   .rsp_entry_rejected (rsp_bus.entry_rejected)
);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the keypad setpoint fan controller beat by beat. Control-loop passes
// are queued in batches (a short directed opening, then random entry sessions
// with noise), driven with random gaps, and every result beat is compared
// against a cycle-free model of the key scan, hysteresis and entry sequencer.
// Duty registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

module testbench;
   import kshfc_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int PHASES      = 8;
   localparam int PHASE_PASSES = 96;

   // scan position to key code, order 1..9,*,0,#
   localparam key_type SCAN_ORDER [12] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
                                           4'd8, 4'd9, KEY_CANCEL, 4'd0, KEY_ENTER};

   typedef struct packed {
      logic       drain;
      sample_type sample;
      lines_type  lines;
   } loop_pass_type;

   typedef struct packed {
      duty_type fan_duty;
      logic     in_setup;
      slot_type entry_position;
      thr_type  off_threshold;
      thr_type  on_threshold;
      thr_type  pending_off;
      thr_type  pending_on;
      key_type  key_event;
      logic     entry_rejected;
   } fan_status_type;

   logic clock;
   logic reset;

   kshfc_req_if req_if ();
   kshfc_rsp_if rsp_if ();
   kshfc_csr_if csr_if ();

   keypad_setpoint_hysteresis_fan_control dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // model state, reset values
   lines_type key_seen = '0;
   level_type fan_lvl  = LEVEL_NONE;
   mode_type  mode     = MODE_MAIN;
   slot_type  cur_slot = SLOT_FIRST;
   thr_type   off_set  = THR_OFF_RST;
   thr_type   on_set   = THR_ON_RST;
   thr_type   off_edit = '0;
   thr_type   on_edit  = '0;
   duty_type  cfg_hi   = DUTY_HIGH_RST;
   duty_type  cfg_lo   = DUTY_LOW_RST;

   loop_pass_type  pass_q [$];
   fan_status_type status_due_q [$];
   loop_pass_type  next_pass;
   fan_status_type want;

   int errors;
   int cycle_count;
   int gap_left;
   int stall_left;
   int taken_count;
   int returned_count;
   int queued;
   bit calm;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic void reload_edits();
      off_edit = off_set;
      on_edit  = on_set;
      cur_slot = SLOT_FIRST;
   endfunction

   // replaces one decimal digit in place; returns 1 when the digit is refused
   function automatic logic digit_refused(inout thr_type v, input pos_type pos,
                                          input key_type d);
      int weight;
      int old_d;
      case (pos)
         POS_HUN: begin
            if (d > HUN_MAX) return 1'b1;
            weight = 100;
         end
         POS_TEN: begin
            if (v == TEN_LIMIT_VAL && d > LOWER_MAX) return 1'b1;
            weight = 10;
         end
         default: begin
            if (v == ONE_LIMIT_VAL && d > LOWER_MAX) return 1'b1;
            weight = 1;
         end
      endcase
      old_d = (int'(v) / weight) % 10;
      v = thr_type'(int'(v) - old_d * weight + int'(d) * weight);
      return 1'b0;
   endfunction

   function automatic fan_status_type fan_step(input sample_type smp, input lines_type lines);
      fan_status_type st;
      key_type key;
      logic bad;
      int i;
      key = KEY_NONE;
      bad = 1'b0;
      // released-to-pressed edge, later scan positions win
      for (i = 0; i < 12; i++)
         if (key_seen[i] && !lines[i]) key = SCAN_ORDER[i];
      key_seen = lines;

      if ({1'b0, smp} > on_set) fan_lvl = LEVEL_HIGH;
      if ({1'b0, smp} < off_set) fan_lvl = LEVEL_LOW;

      if (mode == MODE_MAIN) begin
         if (key == KEY_ENTER) begin
            mode = MODE_SETUP;
            reload_edits();
         end
      end else if (key == KEY_ENTER) begin
         if (cur_slot < SLOT_OFF_WAIT) begin
            if (off_edit == '0) bad = 1'b1;
            else cur_slot = SLOT_ON_FIRST;
         end else if (cur_slot == SLOT_OFF_WAIT) begin
            cur_slot = SLOT_ON_FIRST;
            on_edit  = '0;
         end else if (off_edit < on_edit) begin
            off_set = off_edit;
            on_set  = on_edit;
            mode    = MODE_MAIN;
         end else begin
            bad = 1'b1;
         end
      end else if (key == KEY_CANCEL) begin
         mode = MODE_MAIN;
      end else if (key <= KEY_DIGIT_MAX) begin
         if (cur_slot == SLOT_OFF_WAIT || cur_slot == SLOT_ON_WAIT)
            bad = 1'b1;
         else if (cur_slot < SLOT_OFF_WAIT)
            bad = digit_refused(off_edit, pos_type'(cur_slot), key);
         else
            bad = digit_refused(on_edit, pos_type'(cur_slot - SLOT_ON_FIRST), key);
         if (!bad) cur_slot = cur_slot + 3'd1;
      end
      if (bad) reload_edits();

      if (fan_lvl == LEVEL_HIGH) st.fan_duty = cfg_hi;
      else if (fan_lvl == LEVEL_LOW) st.fan_duty = cfg_lo;
      else st.fan_duty = '0;
      st.in_setup       = (mode == MODE_SETUP);
      st.entry_position = cur_slot;
      st.off_threshold  = off_set;
      st.on_threshold   = on_set;
      st.pending_off    = off_edit;
      st.pending_on     = on_edit;
      st.key_event      = key;
      st.entry_rejected = bad;
      return st;
   endfunction

   function automatic void check_field(input string name, input logic [8:0] exp_val,
                                       input logic [8:0] got);
      if (got !== exp_val) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, got);
         errors++;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic sample_type any_sample();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return sample_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic lines_type key_down(input key_type code);
      lines_type l;
      int i;
      l = '1;
      for (i = 0; i < 12; i++)
         if (SCAN_ORDER[i] == code) l[i] = 1'b0;
      return l;
   endfunction

   function automatic void push_item(input sample_type s, input lines_type l);
      loop_pass_type p;
      p.drain  = 1'b0;
      p.sample = s;
      p.lines  = l;
      pass_q.push_back(p);
      queued++;
   endfunction

   // press a key, usually let it go again on the next pass
   function automatic void tap(input key_type code);
      push_item(any_sample(), key_down(code));
      if ($urandom_range(0, 9) < 7) push_item(any_sample(), '1);
   endfunction

   // one threshold's digits; upper mostly draws a larger hundreds digit so commits tend to succeed
   function automatic void queue_digits(input bit upper);
      int count;
      int n;
      int d;
      count = ($urandom_range(0, 7) < 6) ? 3 : $urandom_range(0, 2);
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 9);
         else if (n == 0) d = upper ? $urandom_range(1, 2) : $urandom_range(0, 1);
         else if ($urandom_range(0, 3) == 0) d = 5;
         else d = $urandom_range(0, 9);
         tap(key_type'(d));
      end
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (!(pass_q.size() == 0 && !req_if.valid && status_due_q.size() == 0));
   endtask

   task automatic write_reg(input csr_index_type idx, input duty_type val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (idx == CSR_DUTY_HIGH) cfg_hi = val;
      else cfg_lo = val;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            status_due_q.push_back(fan_step(req_if.sample, req_if.key_lines));
            taken_count++;
         end
         if (rsp_if.valid && rsp_if.ready) returned_count++;
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pass_q.size() != 0 &&
                         !(pass_q[0].drain && taken_count != returned_count)) begin
               next_pass = pass_q.pop_front();
               req_if.valid     <= 1'b1;
               req_if.sample    <= next_pass.sample;
               req_if.key_lines <= next_pass.lines;
               gap_left = pick_gap();
               if ($urandom_range(0, 63) == 0) calm = !calm;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (status_due_q.size() == 0) begin
               $display("%0t: result beat with nothing expected", $time);
               errors++;
            end else begin
               want = status_due_q.pop_front();
               check_field("fan_duty", 9'(want.fan_duty), 9'(rsp_if.fan_duty));
               check_field("in_setup", 9'(want.in_setup), 9'(rsp_if.in_setup));
               check_field("entry_position", 9'(want.entry_position),
                           9'(rsp_if.entry_position));
               check_field("off_threshold", want.off_threshold, rsp_if.off_threshold);
               check_field("on_threshold", want.on_threshold, rsp_if.on_threshold);
               check_field("pending_off", want.pending_off, rsp_if.pending_off);
               check_field("pending_on", want.pending_on, rsp_if.pending_on);
               check_field("key_event", 9'(want.key_event), 9'(rsp_if.key_event));
               check_field("entry_rejected", 9'(want.entry_rejected),
                           9'(rsp_if.entry_rejected));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int ph;
      int target;
      int roll;
      bit drained;
      duty_type hi;
      duty_type lo;
      loop_pass_type hold_pass;

      reset = 1'b1;
      req_if.valid     = 1'b0;
      req_if.sample    = '0;
      req_if.key_lines = '1;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = CSR_DUTY_HIGH;
      csr_if.data      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening under reset duties
      push_item(8'd0,   '0);                                // keys held since reset
      push_item(8'd255, '1);
      push_item(8'd120, key_down(KEY_CANCEL));              // ignored in main mode
      push_item(8'd80,  key_down(4'd5));                    // ignored in main mode
      push_item(8'd100, key_down(KEY_ENTER));               // open entry
      push_item(8'd50,  key_down(4'd3));                    // hundreds too big
      push_item(8'd60,  key_down(4'd2));
      push_item(8'd70,  key_down(4'd0));
      push_item(8'd90,  key_down(4'd5));
      push_item(8'd101, key_down(4'd1));                    // digit in wait slot
      push_item(8'd99,  key_down(KEY_ENTER));               // to on digits
      push_item(8'd51,  key_down(4'd2));
      push_item(8'd52,  key_down(4'd7));                    // tens over 5 at 200
      push_item(8'd128, key_down(4'd0));
      push_item(8'd49,  '1);
      push_item(8'd127, key_down(4'd0));
      push_item(8'd200, key_down(KEY_ENTER));               // off still zero
      push_item(8'd1,   key_down(4'd9) & key_down(KEY_CANCEL)); // two keys, cancel wins
      push_item(8'd254, key_down(KEY_ENTER));
      push_item(8'd150, key_down(4'd1));
      push_item(8'd151, key_down(4'd0));
      push_item(8'd170, key_down(KEY_ENTER));
      push_item(8'd85,  '1);
      push_item(8'd86,  key_down(KEY_ENTER));               // off not below on
      push_item(8'd87,  key_down(4'd1));
      push_item(8'd88,  key_down(KEY_ENTER));
      push_item(8'd89,  key_down(4'd2));
      push_item(8'd201, key_down(KEY_ENTER));               // commit
      push_item(8'd149, '1);

      for (ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         repeat (2) @(negedge clock);
         case (ph)
            0: begin hi = 7'd0;  lo = 7'd99; end
            1: begin hi = 7'd99; lo = 7'd0;  end
            2: begin hi = 7'd0;  lo = 7'd0;  end
            3: begin hi = 7'd99; lo = 7'd99; end
            default: begin
               hi = duty_type'($urandom_range(0, 99));
               lo = duty_type'($urandom_range(0, 99));
            end
         endcase
         write_reg(CSR_DUTY_HIGH, hi);
         write_reg(CSR_DUTY_LOW, lo);
         @(negedge clock);

         target  = queued + PHASE_PASSES;
         drained = 1'b0;
         while (queued < target) begin
            // once per phase the sender waits for every result first
            if (!drained && queued >= target - PHASE_PASSES / 2) begin
               hold_pass.drain  = 1'b1;
               hold_pass.sample = any_sample();
               hold_pass.lines  = '1;
               pass_q.push_back(hold_pass);
               queued++;
               drained = 1'b1;
            end
            repeat ($urandom_range(0, 2)) push_item(any_sample(), '1);
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
               repeat ($urandom_range(1, 6))
                  push_item(any_sample(), lines_type'($urandom_range(0, 4095)));
            end else begin
               if (roll < 18) tap(key_type'($urandom_range(0, 10)));
               tap(KEY_ENTER);
               queue_digits(1'b0);
               roll = $urandom_range(0, 9);
               if (roll == 8) begin
                  tap(KEY_CANCEL);
               end else begin
                  if (roll == 7) tap(key_type'($urandom_range(0, 9)));
                  if (roll <= 7) tap(KEY_ENTER);
                  queue_digits(1'b1);
                  roll = $urandom_range(0, 9);
                  if (roll == 8) begin
                     tap(KEY_CANCEL);
                  end else begin
                     if (roll == 7) tap(key_type'($urandom_range(0, 9)));
                     if (roll <= 7) tap(KEY_ENTER);
                  end
               end
            end
         end
      end

      wait_idle();
      repeat (4) @(negedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### keypad_setpoint_hysteresis_fan_control.f
+incdir+sv
sv/kshfc_pkg.sv
sv/kshfc_req_if.sv
sv/kshfc_rsp_if.sv
sv/kshfc_csr_if.sv
sv/keypad_setpoint_hysteresis_fan_control.sv
sv/kshfc_checker.sv
sim/testbench.sv
